// ===== rtl/core/tcw_pkg.sv =====
// Package for the text console cell writer.
// Holds screen geometry, codes, payload structs and the control/status types.
// No dependencies.
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELL_COUNT  = ROWS * COLUMNS;
  localparam int CELL_ADDR_W = 11;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 7;
  localparam int CELL_W      = 16;

  // Cell and character codes
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
  localparam logic [7:0]        NL_CODE    = 8'd10;
  localparam logic [7:0]        TAB_CODE   = 8'd9;

  // Request types
  localparam logic [1:0] REQ_PRINT     = 2'd0;
  localparam logic [1:0] REQ_BACKSPACE = 2'd1;
  localparam logic [1:0] REQ_CLEAR     = 2'd2;
  localparam logic [1:0] REQ_READ      = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_COLUMNS = 2'd2;
  localparam int CFG_DATA_W = 8;

  // Configuration reset values
  localparam logic [7:0] TEXT_ATTR_RST      = 8'd15;
  localparam logic [4:0] TAB_WIDTH_RST      = 5'd4;
  localparam logic [6:0] PROMPT_COLUMNS_RST = 7'd8;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [7:0]             char_code;
    logic [CELL_ADDR_W-1:0] cell_index;
  } tcw_req_t;

  typedef struct packed {
    logic [CELL_ADDR_W-1:0] cursor_pos;
    logic [7:0]             read_char;
    logic [7:0]             read_attr;
  } tcw_rsp_t;

  // Cursor column update
  typedef enum logic [2:0] {
    COL_HOLD,
    COL_ZERO,
    COL_INC,
    COL_DEC,
    COL_TAB
  } tcw_col_op_e;

  // Screen store write source
  typedef enum logic [2:0] {
    WR_NONE,
    WR_CHAR_IN,
    WR_CHAR_Q,
    WR_BS,
    WR_COPY,
    WR_BLANK
  } tcw_wr_op_e;

  typedef struct packed {
    logic        capture;
    tcw_col_op_e col_op;
    logic        row_inc;
    logic        row_clr;
    tcw_wr_op_e  wr_op;
    logic        scan_clr;
    logic        scan_inc;
    logic        read_result;
  } tcw_cmd_t;

  typedef struct packed {
    logic wrap;
    logic last_row;
    logic bs_ok;
    logic copy_end;
    logic blank_end;
  } tcw_status_t;

endpackage

// ===== rtl/core/text_console_cell_writer_unit.sv =====
// Top level of the text console cell writer.
// Depends on tcw_pkg, tcw_ctrl, tcw_datapath and tcw_ram.
//
// Usage:
//   Request channel: drive req_i and raise start; the word is taken at a
//   rising edge with start high and busy low.
//   Result channel: each request gives one word on rsp_o, marked by done_o
//   for exactly one cycle; the receiver cannot stall, so it must take it.
//   Config channel: cfg_valid_i with cfg_index_i/cfg_data_i, always ready;
//   write only while no request is in progress.
// Steps per request kind:
//   print of an ordinary byte, tab, newline without scroll, backspace and
//   read: decoded in ST_IDLE, done_o registered from it; one word per cycle
//   sustained while busy is low (one store write or read).
//   wrap without scroll: wrap step in ST_IDLE, then the cell write in ST_PUT.
//   scroll on the last row: ST_COPY moves rows 1 to ROWS-1 up one row, then
//   ST_BLANK blanks the last row, then ST_PUT writes a wrapped byte if any;
//   cells move one at a time through the single write port of the store.
//   clear: ST_BLANK blanks all CELL_COUNT cells, one cell per cycle, from
//   cell 0 up; done_o is registered from its last step.
//   busy stays high while the controller is in ST_COPY, ST_BLANK or ST_PUT.
// Reset clears the cursor and loads the configuration defaults; the screen
// store is not cleared, so cells hold garbage until printed or cleared.
module text_console_cell_writer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  tcw_pkg::tcw_req_t              req_i,
  output logic                           done_o,
  output tcw_pkg::tcw_rsp_t              rsp_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tcw_pkg::*;

  tcw_cmd_t    cmd;
  tcw_status_t status;

  // Config writes are always taken
  assign cfg_ready_o = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .req_i    (req_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  tcw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== rtl/core/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read the array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tcw_datapath.sv =====
// Datapath of the text console cell writer: cursor, configuration, scan counter
// and the screen store. Depends on tcw_pkg and tcw_ram.
module tcw_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcw_pkg::tcw_req_t           req_i,
  input  tcw_pkg::tcw_cmd_t           cmd_i,
  output tcw_pkg::tcw_status_t        status_o,
  input  logic                        cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output tcw_pkg::tcw_rsp_t           rsp_o
);
  import tcw_pkg::*;

  logic [ROW_W-1:0]       row_q, row_d;
  logic [COL_W-1:0]       col_q, col_d;
  logic [CELL_ADDR_W-1:0] scan_q, scan_d;
  logic [7:0]             attr_q;
  logic [4:0]             tab_q;
  logic [6:0]             prompt_q;
  logic [7:0]             char_q;
  logic                   rd_valid_q;

  logic [COL_W:0]         tab_sum;
  logic [CELL_ADDR_W-1:0] cursor_addr;
  logic                   we;
  logic [CELL_ADDR_W-1:0] waddr;
  logic [CELL_W-1:0]      wdata;
  logic [CELL_ADDR_W-1:0] raddr;
  logic [CELL_W-1:0]      rdata;

  // Form the linear cursor address
  assign cursor_addr = CELL_ADDR_W'(row_q) * CELL_ADDR_W'(COLUMNS) + CELL_ADDR_W'(col_q);
  assign tab_sum     = {1'b0, col_q} + (COL_W + 1)'(tab_q);

  // Report status to the controller
  assign status_o.wrap      = (col_q >= COL_W'(COLUMNS));
  assign status_o.last_row  = (row_q == ROW_W'(ROWS - 1));
  assign status_o.bs_ok     = (col_q > prompt_q);
  assign status_o.copy_end  = (scan_q == CELL_ADDR_W'(CELL_COUNT - COLUMNS));
  assign status_o.blank_end = (scan_q == CELL_ADDR_W'(CELL_COUNT - 1));

  // Compute next cursor and scan values
  always_comb begin
    col_d = col_q;
    case (cmd_i.col_op)
      COL_HOLD: col_d = col_q;
      COL_ZERO: col_d = '0;
      COL_INC:  col_d = col_q + COL_W'(1);
      COL_DEC:  col_d = col_q - COL_W'(1);
      COL_TAB: begin
        if (tab_sum > (COL_W + 1)'(COLUMNS)) begin
          col_d = COL_W'(COLUMNS);
        end else begin
          col_d = tab_sum[COL_W-1:0];
        end
      end
      default:  col_d = col_q;
    endcase

    row_d = row_q;
    if (cmd_i.row_clr) begin
      row_d = '0;
    end else if (cmd_i.row_inc) begin
      row_d = row_q + ROW_W'(1);
    end

    scan_d = scan_q;
    if (cmd_i.scan_clr) begin
      scan_d = '0;
    end else if (cmd_i.scan_inc) begin
      scan_d = scan_q + CELL_ADDR_W'(1);
    end
  end

  // Hold cursor, scan counter and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      scan_q     <= '0;
      attr_q     <= TEXT_ATTR_RST;
      tab_q      <= TAB_WIDTH_RST;
      prompt_q   <= PROMPT_COLUMNS_RST;
      rd_valid_q <= 1'b0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      scan_q     <= scan_d;
      rd_valid_q <= cmd_i.read_result && (req_i.cell_index < CELL_ADDR_W'(CELL_COUNT));
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TEXT_ATTR:      attr_q   <= cfg_data_i;
          CFG_TAB_WIDTH:      tab_q    <= cfg_data_i[4:0];
          CFG_PROMPT_COLUMNS: prompt_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  // Latch the character held over a wrap
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      char_q <= req_i.char_code;
    end
  end

  // Select the store write
  always_comb begin
    we    = 1'b0;
    waddr = cursor_addr;
    wdata = BLANK_CELL;
    case (cmd_i.wr_op)
      WR_NONE: we = 1'b0;
      WR_CHAR_IN: begin
        we    = 1'b1;
        wdata = {attr_q, req_i.char_code};
      end
      WR_CHAR_Q: begin
        we    = 1'b1;
        wdata = {attr_q, char_q};
      end
      WR_BS: begin
        we    = 1'b1;
        waddr = cursor_addr - CELL_ADDR_W'(1);
      end
      WR_COPY: begin
        // first scan step only primes the read
        we    = (scan_q != '0);
        waddr = scan_q - CELL_ADDR_W'(1);
        wdata = rdata;
      end
      WR_BLANK: begin
        we    = 1'b1;
        waddr = scan_q;
      end
      default: we = 1'b0;
    endcase
  end

  // Read one row ahead while scrolling, else the requested cell
  assign raddr = (cmd_i.wr_op == WR_COPY) ? (scan_q + CELL_ADDR_W'(COLUMNS)) : req_i.cell_index;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Drive the result word
  assign rsp_o.cursor_pos = cursor_addr;
  assign rsp_o.read_char  = rd_valid_q ? rdata[7:0]  : 8'd0;
  assign rsp_o.read_attr  = rd_valid_q ? rdata[15:8] : 8'd0;

endmodule

// ===== rtl/core/tcw_ctrl.sv =====
// Controller of the text console cell writer: request decode and the
// scroll/clear sequencer. Depends on tcw_pkg.
module tcw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  tcw_pkg::tcw_req_t    req_i,
  input  tcw_pkg::tcw_status_t status_i,
  output tcw_pkg::tcw_cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);
  import tcw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_COPY  = 4'b0010,
    ST_BLANK = 4'b0100,
    ST_PUT   = 4'b1000
  } tcw_state_e;

  tcw_state_e state_q, state_d;
  logic       pend_q, pend_d;
  logic       done_q, done_d;

  // Decode requests and sequence the screen walks
  always_comb begin
    cmd_o   = '{capture: 1'b0, col_op: COL_HOLD, row_inc: 1'b0, row_clr: 1'b0,
                wr_op: WR_NONE, scan_clr: 1'b0, scan_inc: 1'b0, read_result: 1'b0};
    state_d = state_q;
    pend_d  = pend_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (req_i.req_type)
            REQ_PRINT: begin
              if (req_i.char_code == NL_CODE) begin
                cmd_o.col_op = COL_ZERO;
                if (!status_i.last_row) begin
                  cmd_o.row_inc = 1'b1;
                  done_d        = 1'b1;
                end else begin
                  cmd_o.scan_clr = 1'b1;
                  pend_d         = 1'b0;
                  state_d        = ST_COPY;
                end
              end else if (req_i.char_code == TAB_CODE) begin
                cmd_o.col_op = COL_TAB;
                done_d       = 1'b1;
              end else if (!status_i.wrap) begin
                cmd_o.wr_op  = WR_CHAR_IN;
                cmd_o.col_op = COL_INC;
                done_d       = 1'b1;
              end else begin
                // wrap first, then write the held character
                cmd_o.capture = 1'b1;
                cmd_o.col_op  = COL_ZERO;
                if (!status_i.last_row) begin
                  cmd_o.row_inc = 1'b1;
                  state_d       = ST_PUT;
                end else begin
                  cmd_o.scan_clr = 1'b1;
                  pend_d         = 1'b1;
                  state_d        = ST_COPY;
                end
              end
            end
            REQ_BACKSPACE: begin
              if (status_i.bs_ok) begin
                cmd_o.wr_op  = WR_BS;
                cmd_o.col_op = COL_DEC;
              end
              done_d = 1'b1;
            end
            REQ_CLEAR: begin
              cmd_o.row_clr  = 1'b1;
              cmd_o.col_op   = COL_ZERO;
              cmd_o.scan_clr = 1'b1;
              pend_d         = 1'b0;
              state_d        = ST_BLANK;
            end
            REQ_READ: begin
              cmd_o.read_result = 1'b1;
              done_d            = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_COPY: begin
        cmd_o.wr_op = WR_COPY;
        if (status_i.copy_end) begin
          state_d = ST_BLANK;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      ST_BLANK: begin
        cmd_o.wr_op = WR_BLANK;
        if (status_i.blank_end) begin
          if (pend_q) begin
            state_d = ST_PUT;
          end else begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      ST_PUT: begin
        cmd_o.wr_op  = WR_CHAR_Q;
        cmd_o.col_op = COL_INC;
        done_d       = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for text_console_cell_writer_unit.
// Directed and random requests with random idle gaps and register changes between phases.
// Depends on tcw_pkg and the RTL of the block; the scoreboard predicts every result word.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int     CLK_PERIOD      = 20;
  localparam int     GAP_MAX         = 19;
  localparam int     PHASES          = 6;
  localparam int     ITEMS_PER_PHASE = 190;
  localparam int     DRAIN_CYCLES    = 8;
  localparam longint CYCLE_LIMIT     = 10_000_000;
  localparam int     REPORT_MAX      = 10;

  // Index with no register behind it; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  tcw_req_t              req_word    = '0;
  logic                  done;
  tcw_rsp_t              rsp_word;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  longint                cycle_count = 0;
  bit                    burst_mode  = 1'b0;

  text_console_cell_writer_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (req_word),
    .done_o      (done),
    .rsp_o       (rsp_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Screen predictor plus queue of expected result words
  class console_scoreboard;
    logic [CELL_W-1:0] cells [CELL_COUNT];
    bit                known [CELL_COUNT];
    int unsigned       row;
    int unsigned       col;
    logic [7:0]        attr;
    logic [4:0]        tab;
    logic [6:0]        prompt;
    tcw_rsp_t          expected_q[$];
    int unsigned       mismatch_count;

    function new();
      foreach (known[i]) known[i] = 1'b0;
      row            = 0;
      col            = 0;
      attr           = TEXT_ATTR_RST;
      tab            = TAB_WIDTH_RST;
      prompt         = PROMPT_COLUMNS_RST;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TEXT_ATTR:      attr   = data;
        CFG_TAB_WIDTH:      tab    = data[4:0];
        CFG_PROMPT_COLUMNS: prompt = data[6:0];
        default: ;
      endcase
    endfunction

    function void set_cell(int unsigned idx, logic [CELL_W-1:0] value);
      cells[idx] = value;
      known[idx] = 1'b1;
    endfunction

    // Home the column, advance the row or scroll the screen up one row
    function void line_feed();
      col = 0;
      if (row < ROWS - 1) begin
        row++;
      end else begin
        for (int i = 0; i + COLUMNS < CELL_COUNT; i++) begin
          cells[i] = cells[i + COLUMNS];
          known[i] = known[i + COLUMNS];
        end
        for (int c = 0; c < COLUMNS; c++) set_cell((ROWS - 1) * COLUMNS + c, BLANK_CELL);
      end
    endfunction

    function void note_request(tcw_req_t req);
      tcw_rsp_t rsp;
      rsp = '0;
      case (req.req_type)
        REQ_PRINT: begin
          if (req.char_code == NL_CODE) begin
            line_feed();
          end else if (req.char_code == TAB_CODE) begin
            // Saturate at the right edge, no wrap
            col = col + tab;
            if (col > COLUMNS) col = COLUMNS;
          end else begin
            if (col >= COLUMNS) line_feed();
            set_cell(row * COLUMNS + col, {attr, req.char_code});
            col++;
          end
        end
        REQ_BACKSPACE: begin
          if (col > prompt) begin
            col--;
            set_cell(row * COLUMNS + col, BLANK_CELL);
          end
        end
        REQ_CLEAR: begin
          for (int i = 0; i < CELL_COUNT; i++) set_cell(i, BLANK_CELL);
          row = 0;
          col = 0;
        end
        default: begin
          if (req.cell_index < CELL_COUNT) begin
            rsp.read_char = cells[req.cell_index][7:0];
            rsp.read_attr = cells[req.cell_index][15:8];
          end
        end
      endcase
      rsp.cursor_pos = CELL_ADDR_W'(row * COLUMNS + col);
      expected_q.push_back(rsp);
    endfunction

    function void report(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("%s", msg);
    endfunction

    function void check_result(tcw_rsp_t got);
      tcw_rsp_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result word: pos %0d char %02h attr %02h",
                         got.cursor_pos, got.read_char, got.read_attr));
        return;
      end
      exp = expected_q.pop_front();
      if (got.cursor_pos !== exp.cursor_pos || got.read_char !== exp.read_char ||
          got.read_attr !== exp.read_attr) begin
        report($sformatf("result mismatch: pos exp %0d got %0d, char exp %02h got %02h, attr exp %02h got %02h",
                         exp.cursor_pos, got.cursor_pos, exp.read_char, got.read_char,
                         exp.read_attr, got.read_attr));
      end
    endfunction
  endclass

  console_scoreboard sb = new();

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Check every result word on the cycle its strobe is high
  always @(posedge clk) begin
    if (rst_n && done) sb.check_result(rsp_word);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    return burst_mode ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic tcw_req_t make_request(logic [1:0] kind, logic [7:0] code,
                                            logic [CELL_ADDR_W-1:0] idx);
    tcw_req_t req;
    req.req_type   = kind;
    req.char_code  = code;
    req.cell_index = idx;
    return req;
  endfunction

  // Read address: mostly inside the screen, some beyond it; never a cell not yet written
  function automatic logic [CELL_ADDR_W-1:0] pick_cell_index();
    int unsigned idx;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) idx = $urandom_range(0, 2047);
    else if (pick < 6) idx = sb.row * COLUMNS + $urandom_range(0, COLUMNS - 1);
    else idx = $urandom_range(0, CELL_COUNT - 1);
    if (idx < CELL_COUNT && !sb.known[idx]) idx = $urandom_range(CELL_COUNT, 2047);
    return CELL_ADDR_W'(idx);
  endfunction

  // Mostly printable text with line breaks, tabs, raw bytes, edits, reads and rare clears mixed in
  function automatic tcw_req_t random_request();
    tcw_req_t    req;
    int unsigned pick;
    req  = make_request(REQ_PRINT, 8'($urandom_range(8'h20, 8'h7E)),
                        CELL_ADDR_W'($urandom_range(0, 2047)));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // printable byte as drawn
    end else if (pick < 66) begin
      req.char_code = NL_CODE;
    end else if (pick < 71) begin
      req.char_code = TAB_CODE;
    end else if (pick < 75) begin
      req.char_code = 8'($urandom_range(0, 255));
    end else if (pick < 85) begin
      req.req_type  = REQ_BACKSPACE;
      req.char_code = 8'($urandom_range(0, 255));
    end else if (pick < 98) begin
      req.req_type   = REQ_READ;
      req.char_code  = 8'($urandom_range(0, 255));
      req.cell_index = pick_cell_index();
    end else begin
      req.req_type  = REQ_CLEAR;
      req.char_code = 8'($urandom_range(0, 255));
    end
    return req;
  endfunction

  // Hold start high until the word is taken, then note it; start stays high on return
  task automatic send_request(tcw_req_t req, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    req_word <= req;
    do @(posedge clk); while (busy);
    sb.note_request(req);
  endtask

  // Drop start and wait until every expected word has come back
  task automatic wait_for_idle();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(logic [7:0] attr, logic [7:0] tab_data, logic [7:0] prompt_data);
    wait_for_idle();
    write_register(CFG_TEXT_ATTR, attr);
    write_register(CFG_TAB_WIDTH, tab_data);
    write_register(CFG_PROMPT_COLUMNS, prompt_data);
    write_register(CFG_UNMAPPED, 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] attr;
    logic [7:0] tab_data;
    logic [7:0] prompt_data;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first write, reads in and beyond range, clear, byte extremes, tab, ignored backspace
    send_request(make_request(REQ_PRINT, 8'h41, '0), draw_gap());
    send_request(make_request(REQ_READ, 8'h00, '0), draw_gap());
    send_request(make_request(REQ_READ, 8'h00, 11'h7FF), draw_gap());
    send_request(make_request(REQ_READ, 8'h00, CELL_ADDR_W'(CELL_COUNT)), draw_gap());
    send_request(make_request(REQ_CLEAR, 8'hFF, 11'h7FF), draw_gap());
    send_request(make_request(REQ_READ, 8'h00, CELL_ADDR_W'(CELL_COUNT - 1)), draw_gap());
    send_request(make_request(REQ_PRINT, 8'h00, '0), draw_gap());
    send_request(make_request(REQ_PRINT, 8'hFF, '0), draw_gap());
    send_request(make_request(REQ_PRINT, NL_CODE, '0), draw_gap());
    send_request(make_request(REQ_PRINT, TAB_CODE, '0), draw_gap());
    send_request(make_request(REQ_BACKSPACE, 8'h00, '0), draw_gap());
    send_request(make_request(REQ_PRINT, 8'h1B, '0), draw_gap());
    send_request(make_request(REQ_READ, 8'h00, CELL_ADDR_W'(COLUMNS + 4)), draw_gap());

    // Directed: wide tab saturating at the edge, wrap after it, backspace down to the prompt
    configure(8'hF0, 8'h1F, 8'h00);
    repeat (3) send_request(make_request(REQ_PRINT, TAB_CODE, '0), draw_gap());
    send_request(make_request(REQ_BACKSPACE, 8'h00, '0), draw_gap());
    send_request(make_request(REQ_PRINT, TAB_CODE, '0), draw_gap());
    send_request(make_request(REQ_PRINT, 8'h5A, '0), draw_gap());
    repeat (2) send_request(make_request(REQ_BACKSPACE, 8'h00, '0), draw_gap());
    send_request(make_request(REQ_READ, 8'h00, CELL_ADDR_W'(2 * COLUMNS)), draw_gap());

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin attr = TEXT_ATTR_RST; tab_data = 8'(TAB_WIDTH_RST); prompt_data = 8'(PROMPT_COLUMNS_RST); end
        1: begin attr = 8'h00; tab_data = 8'h01; prompt_data = 8'h00; end
        2: begin attr = 8'hFF; tab_data = 8'h10; prompt_data = 8'd79; end
        3: begin attr = 8'hA5; tab_data = 8'hE0; prompt_data = 8'hFF; end
        4: begin attr = 8'h5A; tab_data = 8'h03; prompt_data = 8'h82; end
        default: begin
          attr        = 8'($urandom_range(0, 255));
          tab_data    = 8'($urandom_range(0, 255));
          prompt_data = 8'($urandom_range(0, 255)) & 8'hBF;
        end
      endcase
      configure(attr, tab_data, prompt_data);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 16 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        send_request(random_request(), draw_gap());
      end
    end

    wait_for_idle();
    if (sb.mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
